[rtl/chtu_pkg.sv]
// Package for the coalesced hash table unit: sizes, transaction payload types,
// stored row layout and status codes. No dependencies.
package chtu_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 40;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int SIZE_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int STEP_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int DIGIT_BITS  = 4;
  localparam int MOD_STEPS   = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int MOD_CNT_BITS = $clog2(MOD_STEPS + 1);
  localparam int MOD_WIDTH   = MOD_STEPS * DIGIT_BITS;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [VALUE_BITS-1:0] found_value;
    logic [IDX_BITS-1:0]   slot;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [IDX_BITS-1:0]   link;
  } row_t;

endpackage

[rtl/chtu_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module chtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/chtu_mod.sv]
// Iterative remainder unit: dividend modulo a small divisor, one hex digit per cycle.
// Depends on chtu_pkg.
module chtu_mod (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [chtu_pkg::KEY_BITS-1:0]      dividend,
  input  logic [chtu_pkg::SIZE_BITS-1:0]     divisor,
  output logic                               done,
  output logic [chtu_pkg::IDX_BITS-1:0]      rem
);

  logic [chtu_pkg::MOD_WIDTH-1:0]    shreg;
  logic [chtu_pkg::SIZE_BITS-1:0]    dsr;
  logic [chtu_pkg::SIZE_BITS-1:0]    part;
  logic [chtu_pkg::SIZE_BITS-1:0]    part_next;
  logic [chtu_pkg::MOD_CNT_BITS-1:0] count;
  logic                              busy;

  always_comb begin
    logic [chtu_pkg::SIZE_BITS-1:0] r;
    r = part;
    for (int i = 0; i < chtu_pkg::DIGIT_BITS; i++) begin
      r = {r[chtu_pkg::SIZE_BITS-2:0], shreg[chtu_pkg::MOD_WIDTH-1-i]};
      if (r >= dsr) begin
        r = r - dsr;
      end
    end
    part_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= chtu_pkg::MOD_WIDTH'(dividend);
        dsr   <= divisor;
        part  <= '0;
        count <= '0;
      end else if (busy) begin
        part  <= part_next;
        shreg <= shreg << chtu_pkg::DIGIT_BITS;
        count <= count + 1'b1;
        if (count == chtu_pkg::MOD_CNT_BITS'(chtu_pkg::MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = part[chtu_pkg::IDX_BITS-1:0];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (part < dsr)) else $error("remainder not below divisor");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("remainder unit restarted while busy");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("remainder done held for two cycles");

endmodule

[rtl/coalesced_hash_table_unit.sv]
// Top level of the coalesced hash table unit: sequencer, slot RAM and valid bits.
// Depends on chtu_pkg, chtu_ram and chtu_mod.
//
// Requests arrive on req (op, key, value) under req_valid/req_ready; each produces
// exactly one response on rsp (status, found_value, slot) under rsp_valid/rsp_ready.
// One transaction is worked on at a time. The home slot comes from the remainder
// unit (four key bits a cycle), then each chain entry takes one RAM read. A search
// follows the links from the home slot; an insert into an empty home slot writes
// its row there. An insert that collides walks the chain, runs the remainder unit a
// second time for the probe start, probes one slot a cycle and writes two rows, or
// none when the table is full. A key of zero skips the remainder unit and goes
// straight to the response. The next request is accepted in the cycle after the
// response is registered.
// The response sits in an output register: the next request is accepted while a
// response still waits, and the unit stalls only when a second one is ready.
// Reset empties the table at once through per-slot valid bits (no clearing pass)
// and sets the table size to 16. The user writes the table size through
// cfg_wr_en/cfg_wr_data only while no transaction is in flight; the block does not enforce this.
module coalesced_hash_table_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  chtu_pkg::req_t                     req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output chtu_pkg::rsp_t                     rsp,
  input  logic                               cfg_wr_en,
  input  logic [chtu_pkg::SIZE_BITS-1:0]     cfg_wr_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_CHECK, S_PROBE_MOD, S_PROBE, S_WR_LINK, S_DONE
  } state_t;

  state_t                            state;
  logic [chtu_pkg::SIZE_BITS-1:0]    table_size;
  logic [chtu_pkg::SIZE_BITS-1:0]    size;
  logic [chtu_pkg::SIZE_BITS-1:0]    size_next;
  logic                              op;
  logic [chtu_pkg::KEY_BITS-1:0]     key;
  logic [chtu_pkg::VALUE_BITS-1:0]   value;
  logic [chtu_pkg::IDX_BITS-1:0]     cur;
  logic [chtu_pkg::IDX_BITS-1:0]     cur_next;
  logic [chtu_pkg::IDX_BITS-1:0]     cand;
  logic [chtu_pkg::IDX_BITS-1:0]     end_idx;
  chtu_pkg::row_t                    end_row;
  logic [chtu_pkg::STEP_BITS-1:0]    steps;
  logic [chtu_pkg::SIZE_BITS-1:0]    probes;
  logic [chtu_pkg::TABLE_DEPTH-1:0]  key_valid;
  logic [chtu_pkg::TABLE_DEPTH-1:0]  link_valid;
  chtu_pkg::rsp_t                    result;

  chtu_pkg::row_t                    rd_row;
  chtu_pkg::row_t                    wr_row;
  logic                              wr_en;
  logic [chtu_pkg::IDX_BITS-1:0]     wr_addr;
  logic                              occupied;
  logic                              linked;
  logic                              follow;
  logic [chtu_pkg::SIZE_BITS-1:0]    cand_inc;

  logic                              mod_start;
  logic [chtu_pkg::KEY_BITS-1:0]     mod_dividend;
  logic                              mod_done;
  logic [chtu_pkg::IDX_BITS-1:0]     mod_rem;

  always_comb begin
    if (cfg_wr_data == '0) begin
      size_next = chtu_pkg::SIZE_BITS'(1);
    end else if (cfg_wr_data > chtu_pkg::SIZE_RESET) begin
      size_next = chtu_pkg::SIZE_RESET;
    end else begin
      size_next = cfg_wr_data;
    end
  end

  assign req_ready = (state == S_IDLE);
  assign occupied  = key_valid[cur];
  assign linked    = link_valid[cur];
  assign follow    = linked && (steps < chtu_pkg::STEP_BITS'(chtu_pkg::TABLE_DEPTH));
  assign cand_inc  = chtu_pkg::SIZE_BITS'(cand) + 1'b1;

  always_comb begin
    case (state)
      S_MOD:   cur_next = mod_rem;
      S_CHECK: cur_next = rd_row.link;
      default: cur_next = cur;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cand;
    wr_row  = '{key: key, value: value, link: '0};
    case (state)
      S_CHECK: begin
        if (op == chtu_pkg::OP_INSERT && steps == '0 && !occupied) begin
          wr_en   = 1'b1;
          wr_addr = cur;
        end
      end
      S_PROBE: begin
        wr_en = !key_valid[cand];
      end
      S_WR_LINK: begin
        wr_en   = 1'b1;
        wr_addr = end_idx;
        wr_row  = '{key: end_row.key, value: end_row.value, link: cand};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = req.key;
    case (state)
      S_IDLE: mod_start = req_valid && (req.key != '0);
      S_CHECK: begin
        mod_dividend = chtu_pkg::KEY_BITS'(cur) + 1'b1;
        mod_start    = (op == chtu_pkg::OP_INSERT) && !(steps == '0 && !occupied)
                       && !follow;
      end
      default: mod_start = 1'b0;
    endcase
  end

  chtu_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  ((state == S_IDLE) ? table_size : size),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  chtu_ram #(
    .WIDTH ($bits(chtu_pkg::row_t)),
    .DEPTH (chtu_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_row),
    .raddr (cur_next),
    .rdata (rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= chtu_pkg::SIZE_RESET;
      key_valid  <= '0;
      link_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_size <= size_next;
      end
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      cur <= cur_next;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.op;
            key   <= req.key;
            value <= req.value;
            size  <= table_size;
            steps <= '0;
            if (req.key == '0) begin
              result <= '{status: (req.op == chtu_pkg::OP_SEARCH) ? chtu_pkg::ST_MISSING
                                                                : chtu_pkg::ST_FULL,
                          found_value: '0, slot: '0};
              state  <= S_DONE;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (op == chtu_pkg::OP_SEARCH) begin
            if (occupied && rd_row.key == key) begin
              result <= '{status: chtu_pkg::ST_FOUND, found_value: rd_row.value, slot: cur};
              state  <= S_DONE;
            end else if (follow) begin
              steps <= steps + 1'b1;
            end else begin
              result <= '{status: chtu_pkg::ST_MISSING, found_value: '0, slot: '0};
              state  <= S_DONE;
            end
          end else if (steps == '0 && !occupied) begin
            key_valid[cur] <= 1'b1;
            result <= '{status: chtu_pkg::ST_INSERTED, found_value: '0, slot: cur};
            state  <= S_DONE;
          end else if (follow) begin
            steps <= steps + 1'b1;
          end else begin
            end_idx <= cur;
            end_row <= rd_row;
            state   <= S_PROBE_MOD;
          end
        end
        S_PROBE_MOD: begin
          if (mod_done) begin
            cand   <= mod_rem;
            probes <= '0;
            state  <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!key_valid[cand]) begin
            key_valid[cand] <= 1'b1;
            state <= S_WR_LINK;
          end else if (probes == size - 1'b1) begin
            result <= '{status: chtu_pkg::ST_FULL, found_value: '0, slot: '0};
            state  <= S_DONE;
          end else begin
            probes <= probes + 1'b1;
            cand   <= (cand_inc == size) ? '0 : cand_inc[chtu_pkg::IDX_BITS-1:0];
          end
        end
        S_WR_LINK: begin
          link_valid[end_idx] <= 1'b1;
          result <= '{status: chtu_pkg::ST_INSERTED, found_value: '0, slot: cand};
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= result;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_link_from_occupied: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_LINK) |-> (key_valid[end_idx] && key_valid[cand] && end_idx != cand))
    else $error("chain link written from an empty slot or to itself");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (chtu_pkg::SIZE_BITS'(cand) < size))
    else $error("probe slot outside the table size");

  a_write_empty_slot: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state != S_WR_LINK) |-> !key_valid[wr_addr])
    else $error("new key written over an occupied slot");

endmodule
